// ===== rtl/pvad_pkg.sv =====
// ----------------------------------------------------------------------------
// pvad_pkg
// Shared widths, operation and region codes, and the decoded request struct
// for the video-memory access decoder.
// ----------------------------------------------------------------------------
package pvad_pkg;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 8;
    localparam int PIX_N      = 8;
    localparam int ROW_W      = 2 * PIX_N;
    localparam int MIRROR_W   = 3;
    localparam int PAL_W      = 6;
    localparam int PAT_DEPTH  = 4096;
    localparam int NT_DEPTH   = 4096;
    localparam int PAL_DEPTH  = 32;
    localparam int PAT_IDX_W  = $clog2(PAT_DEPTH);
    localparam int NT_IDX_W   = $clog2(NT_DEPTH);
    localparam int PAL_IDX_W  = $clog2(PAL_DEPTH);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [OP_W-1:0] OP_RD_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_BYTE = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_ROW  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [MIRROR_W-1:0] MIR_VERT     = 3'd0;
    localparam logic [MIRROR_W-1:0] MIR_HORZ     = 3'd1;
    localparam logic [MIRROR_W-1:0] MIR_ONE_LOW  = 3'd2;
    localparam logic [MIRROR_W-1:0] MIR_ONE_HIGH = 3'd3;
    localparam logic [MIRROR_W-1:0] MIR_FOUR     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_ROM = 1'd1;

    localparam logic [1:0] REG_PAT = 2'd0;
    localparam logic [1:0] REG_NT  = 2'd1;
    localparam logic [1:0] REG_PAL = 2'd2;

    localparam logic [5:0] PAL_PAGE = 6'h3f;

    typedef struct packed {
        logic [1:0]           region;
        logic                 plane;
        logic [PAT_IDX_W-1:0] pat_idx;
        logic [NT_IDX_W-1:0]  nt_idx;
        logic [PAL_IDX_W-1:0] pal_idx;
        logic                 pat_we;
        logic                 nt_we;
        logic                 pal_we;
        logic                 dropped;
    } t_req;

endpackage

// ===== rtl/pvad_if.sv =====
// ----------------------------------------------------------------------------
// pvad_if
// Valid/ready channels for access beats in and result beats out.
// ----------------------------------------------------------------------------
interface pvad_in_if;
    import pvad_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, operation, address, write_data, input ready);
    modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface pvad_out_if;
    import pvad_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [ROW_W-1:0]  decoded_row;
    logic              write_dropped;

    modport source (output valid, read_data, decoded_row, write_dropped, input ready);
    modport sink   (input valid, read_data, decoded_row, write_dropped, output ready);
endinterface

// ===== rtl/pvad_decode.sv =====
// ----------------------------------------------------------------------------
// pvad_decode
// Address decode: region select, name-table mirroring, palette pairing and
// write-enable generation for one access beat.
// ----------------------------------------------------------------------------
module pvad_decode (
    input  logic [pvad_pkg::OP_W-1:0]     i_op,
    input  logic [pvad_pkg::ADDR_W-1:0]   i_addr,
    input  logic [pvad_pkg::MIRROR_W-1:0] i_mirror,
    input  logic                          i_pat_rom,
    output pvad_pkg::t_req                o_req
);
    import pvad_pkg::*;

    logic [1:0] tbl;
    logic [1:0] page;
    logic       wr;

    assign tbl = i_addr[11:10];
    assign wr  = (i_op == OP_WR_BYTE);

    always_comb begin
        unique case (i_mirror)
            MIR_VERT:     page = {1'b0, tbl[0]};
            MIR_HORZ:     page = {1'b0, tbl[1]};
            MIR_ONE_LOW:  page = 2'd0;
            MIR_ONE_HIGH: page = 2'd1;
            default:      page = tbl;
        endcase
    end

    always_comb begin
        if (!i_addr[13]) begin
            o_req.region = REG_PAT;
        end else if (i_addr[13:8] == PAL_PAGE) begin
            o_req.region = REG_PAL;
        end else begin
            o_req.region = REG_NT;
        end
        o_req.plane   = i_addr[3];
        o_req.pat_idx = {i_addr[12:4], i_addr[2:0]};
        o_req.nt_idx  = {page, i_addr[9:0]};
        o_req.pal_idx = (i_addr[3:0] == 4'd0) ? '0 : i_addr[PAL_IDX_W-1:0];
        o_req.pat_we  = wr && (o_req.region == REG_PAT) && !i_pat_rom;
        o_req.nt_we   = wr && (o_req.region == REG_NT);
        o_req.pal_we  = wr && (o_req.region == REG_PAL);
        o_req.dropped = wr && (o_req.region == REG_PAT) && i_pat_rom;
    end

endmodule

// ===== rtl/pvad_ram.sv =====
// ----------------------------------------------------------------------------
// pvad_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pvad_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pvad_pat_mem.sv =====
// ----------------------------------------------------------------------------
// pvad_pat_mem
// Pattern store as two bit-plane banks, one row per entry; both banks are
// read together to form a decoded pixel row. Cleared after reset.
// ----------------------------------------------------------------------------
module pvad_pat_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_we,
    input  logic                           i_plane,
    input  logic [pvad_pkg::PAT_IDX_W-1:0] i_idx,
    input  logic [pvad_pkg::DATA_W-1:0]    i_wdata,
    output logic [pvad_pkg::DATA_W-1:0]    o_rd0,
    output logic [pvad_pkg::DATA_W-1:0]    o_rd1,
    output logic                           o_ready
);
    import pvad_pkg::*;

    logic [DATA_W-1:0]    r_bank0 [PAT_DEPTH];
    logic [DATA_W-1:0]    r_bank1 [PAT_DEPTH];
    logic [DATA_W-1:0]    r_rd0;
    logic [DATA_W-1:0]    r_rd1;
    logic                 r_clr_busy;
    logic [PAT_IDX_W-1:0] r_clr_addr;

    // clearing sweep, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_bank0[r_clr_addr] <= '0;
        end else if (i_en && i_we && !i_plane) begin
            r_bank0[i_idx] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_bank1[r_clr_addr] <= '0;
        end else if (i_en && i_we && i_plane) begin
            r_bank1[i_idx] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd0 <= r_bank0[i_idx];
            r_rd1 <= r_bank1[i_idx];
        end
    end

    assign o_rd0   = r_rd0;
    assign o_rd1   = r_rd1;
    assign o_ready = !r_clr_busy;

endmodule

// ===== rtl/ppu_vram_access_decoder.sv =====
// ----------------------------------------------------------------------------
// ppu_vram_access_decoder
// Result beat: presented in the cycle after the access beat is accepted.
// Throughput: one access per cycle while the result stage can advance.
// Reset: configuration and result-valid registers cleared; the pattern planes
// are swept to zero after reset, during which no access beat is accepted.
// Decodes video-memory accesses to pattern, name-table and palette stores.
// ----------------------------------------------------------------------------
module ppu_vram_access_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pvad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pvad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pvad_in_if.sink                         i_in,
    pvad_out_if.source                      o_out
);
    import pvad_pkg::*;

    logic [MIRROR_W-1:0] r_mirror;
    logic                r_pat_rom;
    logic                r_s1_valid;
    logic [OP_W-1:0]     r_s1_op;
    logic [1:0]          r_s1_region;
    logic                r_s1_plane;
    logic                r_s1_dropped;

    t_req              req;
    logic              pat_ready;
    logic              accept;
    logic [DATA_W-1:0] pat_rd0;
    logic [DATA_W-1:0] pat_rd1;
    logic [DATA_W-1:0] nt_rd;
    logic [PAL_W-1:0]  pal_rd;
    logic [ROW_W-1:0]  row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror  <= '0;
            r_pat_rom <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIRROR:  r_mirror  <= i_cfg_data;
                CFG_PAT_ROM: r_pat_rom <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    pvad_decode u_decode (
        .i_op      (i_in.operation),
        .i_addr    (i_in.address),
        .i_mirror  (r_mirror),
        .i_pat_rom (r_pat_rom),
        .o_req     (req)
    );

    assign i_in.ready = pat_ready && (!r_s1_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    pvad_pat_mem u_pat_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_we    (req.pat_we),
        .i_plane (req.plane),
        .i_idx   (req.pat_idx),
        .i_wdata (i_in.write_data),
        .o_rd0   (pat_rd0),
        .o_rd1   (pat_rd1),
        .o_ready (pat_ready)
    );

    pvad_ram #(
        .DEPTH (NT_DEPTH),
        .WIDTH (DATA_W)
    ) u_nt_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (req.nt_we),
        .i_addr  (req.nt_idx),
        .i_wdata (i_in.write_data),
        .o_rdata (nt_rd)
    );

    pvad_ram #(
        .DEPTH (PAL_DEPTH),
        .WIDTH (PAL_W)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (req.pal_we),
        .i_addr  (req.pal_idx),
        .i_wdata (i_in.write_data[PAL_W-1:0]),
        .o_rdata (pal_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= i_in.operation;
            r_s1_region  <= req.region;
            r_s1_plane   <= req.plane;
            r_s1_dropped <= req.dropped;
        end
    end

    always_comb begin
        for (int j = 0; j < PIX_N; j++) begin
            row[2*j]   = pat_rd0[j];
            row[2*j+1] = pat_rd1[j];
        end
    end

    always_comb begin
        o_out.read_data = '0;
        if (r_s1_op == OP_RD_BYTE) begin
            unique case (r_s1_region)
                REG_PAT: o_out.read_data = r_s1_plane ? pat_rd1 : pat_rd0;
                REG_NT:  o_out.read_data = nt_rd;
                default: o_out.read_data = {{(DATA_W-PAL_W){1'b0}}, pal_rd};
            endcase
        end
    end

    assign o_out.valid         = r_s1_valid;
    assign o_out.decoded_row   = (r_s1_op == OP_RD_ROW) ? row : '0;
    assign o_out.write_dropped = r_s1_dropped;

endmodule

// ===== dv/vram_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_access_checker
// Watches the access and result channels of the video-memory decoder, keeps
// its own copy of the pattern, name-table, palette and decoded pixel stores,
// and compares every result beat field by field with the predicted reply.
// ----------------------------------------------------------------------------
module vram_access_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pvad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pvad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pvad_in_if                              i_acc,
    pvad_out_if                             i_res,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import pvad_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [ROW_W-1:0]  decoded_row;
        logic              write_dropped;
    } t_reply;

    logic [DATA_W-1:0]   pattern_bytes   [8192];
    logic [DATA_W-1:0]   nametable_bytes [4096];
    logic [PAL_W-1:0]    palette_entries [32];
    logic [1:0]          pixel_planes    [32768];
    logic [MIRROR_W-1:0] mirror_mode;
    logic                pattern_rom;
    t_reply              replies_due[$];
    int                  mismatch_total = 0;

    function automatic logic [11:0] nt_slot(input logic [ADDR_W-1:0] a);
        logic [1:0] t;
        logic [1:0] pg;
        t = a[11:10];
        case (mirror_mode)
            MIR_VERT:     pg = {1'b0, t[0]};
            MIR_HORZ:     pg = {1'b0, t[1]};
            MIR_ONE_LOW:  pg = 2'd0;
            MIR_ONE_HIGH: pg = 2'd1;
            default:      pg = t;
        endcase
        return {pg, a[9:0]};
    endfunction

    function automatic logic [14:0] row_origin(input logic [ADDR_W-1:0] a);
        return {a[12:4], a[2:0], 3'b000};
    endfunction

    function automatic t_reply apply_access(input logic [OP_W-1:0] op,
                                            input logic [ADDR_W-1:0] a,
                                            input logic [DATA_W-1:0] v);
        t_reply      r;
        logic [14:0] base;
        logic [4:0]  e;
        r    = '0;
        base = row_origin(a);
        e    = a[4:0];
        case (op)
            OP_RD_BYTE: begin
                if (!a[13]) begin
                    r.read_data = pattern_bytes[a[12:0]];
                end else if (a[13:8] == PAL_PAGE) begin
                    r.read_data = {2'b00, palette_entries[e]};
                end else begin
                    r.read_data = nametable_bytes[nt_slot(a)];
                end
            end
            OP_WR_BYTE: begin
                if (!a[13]) begin
                    if (pattern_rom) begin
                        r.write_dropped = 1'b1;
                    end else begin
                        pattern_bytes[a[12:0]] = v;
                        for (int j = 0; j < PIX_N; j++) begin
                            if (a[3]) begin
                                pixel_planes[base | 15'(j)][1] = v[j];
                            end else begin
                                pixel_planes[base | 15'(j)][0] = v[j];
                            end
                        end
                    end
                end else if (a[13:8] == PAL_PAGE) begin
                    if (e[3:0] == 4'h0) begin
                        palette_entries[0]  = v[PAL_W-1:0];
                        palette_entries[16] = v[PAL_W-1:0];
                    end else begin
                        palette_entries[e] = v[PAL_W-1:0];
                    end
                end else begin
                    nametable_bytes[nt_slot(a)] = v;
                end
            end
            OP_RD_ROW: begin
                for (int j = 0; j < PIX_N; j++) begin
                    r.decoded_row[2*j +: 2] = pixel_planes[base | 15'(j)];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            mirror_mode = MIR_VERT;
            pattern_rom = 1'b0;
            replies_due.delete();
            for (int k = 0; k < 32768; k++) begin
                pixel_planes[k] = 2'b00;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MIRROR) begin
                    mirror_mode = i_cfg_data;
                end else if (i_cfg_index == CFG_PAT_ROM) begin
                    pattern_rom = i_cfg_data[0];
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no access outstanding");
                    mismatch_total++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_res.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, i_res.read_data);
                        mismatch_total++;
                    end
                    if (i_res.decoded_row !== want.decoded_row) begin
                        $error("decoded_row: expected %0h, got %0h",
                               want.decoded_row, i_res.decoded_row);
                        mismatch_total++;
                    end
                    if (i_res.write_dropped !== want.write_dropped) begin
                        $error("write_dropped: expected %0b, got %0b",
                               want.write_dropped, i_res.write_dropped);
                        mismatch_total++;
                    end
                end
            end
            if (i_acc.valid && i_acc.ready) begin
                replies_due.push_back(apply_access(i_acc.operation, i_acc.address,
                                                   i_acc.write_data));
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= replies_due.size();
    end

endmodule

// ===== dv/tb_ppu_vram_access_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppu_vram_access_decoder
// Drives byte reads, byte writes and decoded-row reads into the decoder
// across all mirroring modes and both pattern ROM settings, with bursty
// input traffic, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_ppu_vram_access_decoder;
    import pvad_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 20000;
    localparam int FLOOD_HOLD   = 300;
    localparam int PHASE_ITEMS  = 110;
    localparam int PHASES       = 8;
    localparam int FLOOD_PHASE  = 3;

    localparam logic [MIRROR_W-1:0] MIR_SPARE_A = 3'd5;
    localparam logic [MIRROR_W-1:0] MIR_SPARE_B = 3'd6;
    localparam logic [MIRROR_W-1:0] MIR_SPARE_C = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  flood_req = 1'b0;
    bit                    flood_served;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    bit                    no_gaps = 1'b0;
    logic [MIRROR_W-1:0]   cur_mode = MIR_VERT;
    logic                  cur_rom = 1'b0;
    bit                    pat_written [8192];
    bit                    nt_written  [4096];
    bit                    pal_written [32];

    pvad_in_if  acc_ch ();
    pvad_out_if res_ch ();

    ppu_vram_access_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (acc_ch),
        .o_out       (res_ch)
    );

    vram_access_checker access_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_acc         (acc_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [11:0] nt_slot_of(input logic [ADDR_W-1:0] a);
        logic [1:0] t;
        logic [1:0] pg;
        t = a[11:10];
        case (cur_mode)
            MIR_VERT:     pg = {1'b0, t[0]};
            MIR_HORZ:     pg = {1'b0, t[1]};
            MIR_ONE_LOW:  pg = 2'd0;
            MIR_ONE_HIGH: pg = 2'd1;
            default:      pg = t;
        endcase
        return {pg, a[9:0]};
    endfunction

    function automatic bit readable(input logic [ADDR_W-1:0] a);
        if (!a[13]) return pat_written[a[12:0]];
        if (a[13:8] == PAL_PAGE) return pal_written[a[4:0]];
        return nt_written[nt_slot_of(a)];
    endfunction

    function automatic void note_write(input logic [ADDR_W-1:0] a);
        if (!a[13]) begin
            if (!cur_rom) pat_written[a[12:0]] = 1'b1;
        end else if (a[13:8] == PAL_PAGE) begin
            if (a[3:0] == 4'h0) begin
                pal_written[0]  = 1'b1;
                pal_written[16] = 1'b1;
            end else begin
                pal_written[a[4:0]] = 1'b1;
            end
        end else begin
            nt_written[nt_slot_of(a)] = 1'b1;
        end
    endfunction

    task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                         input logic [DATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (!no_gaps && gap > 0) begin
                acc_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        acc_ch.valid      <= 1'b1;
        acc_ch.operation  <= op;
        acc_ch.address    <= a;
        acc_ch.write_data <= d;
        do @(posedge i_clk); while (!acc_ch.ready);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                         input logic [DATA_W-1:0] d);
        if (op == OP_WR_BYTE) note_write(a);
        offer(op, a, d);
    endtask

    task automatic roll_access(output logic [OP_W-1:0] op, output logic [ADDR_W-1:0] a,
                               output logic [DATA_W-1:0] d);
        int         region;
        int         pick;
        logic [8:0] tile;
        d      = DATA_W'($urandom_range(0, 255));
        region = $urandom_range(0, 99);
        if (region < 45) begin
            if ($urandom_range(0, 1)) begin
                tile = 9'($urandom_range(0, 7));
                if (tile > 3) tile = tile + 9'h1f4;
                a = {1'b0, tile, 4'($urandom_range(0, 15))};
            end else begin
                a = ADDR_W'($urandom_range(0, 14'h1fff));
            end
        end else if (region < 80) begin
            if ($urandom_range(0, 1)) begin
                a = {1'b1, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 5'b00000,
                     5'($urandom_range(0, 31))};
            end else begin
                a = ADDR_W'($urandom_range(14'h2000, 14'h3eff));
            end
        end else begin
            a = {PAL_PAGE, 8'($urandom_range(0, 255))};
        end
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            op = OP_WR_BYTE;
        end else if (pick < 76) begin
            op = OP_RD_BYTE;
        end else if (pick < 94) begin
            op = OP_RD_ROW;
            if ($urandom_range(0, 3) == 0) a = ADDR_W'($urandom_range(0, 14'h3fff));
        end else begin
            op = OP_NONE;
        end
        if (op == OP_RD_BYTE && !readable(a)) begin
            op = (!a[13] && cur_rom) ? OP_RD_ROW : OP_WR_BYTE;
        end
    endtask

    task automatic settle();
        acc_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MIRROR_W-1:0] mode, input logic rom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIRROR;
        cfg_data  <= mode;
        @(posedge i_clk);
        cfg_index <= CFG_PAT_ROM;
        cfg_data  <= {2'($urandom_range(0, 3)), rom};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_mode = mode;
        cur_rom  = rom;
    endtask

    // receiver: random stall styles, plus one long hold-off on request
    initial begin
        int style;
        int span;
        style        = 0;
        span         = 0;
        flood_served = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (flood_req && !flood_served) begin
                res_ch.ready <= 1'b0;
                repeat (FLOOD_HOLD) @(posedge i_clk);
                flood_served = 1'b1;
                res_ch.ready <= 1'b1;
            end else begin
                if (span == 0) begin
                    style = $urandom_range(0, 3);
                    span  = $urandom_range(10, 80);
                end
                span--;
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= span[0];
                    default: res_ch.ready <= ((span % 7) > 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((acc_ch.valid && acc_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [MIRROR_W-1:0] phase_mode [PHASES];
        logic                phase_rom  [PHASES];
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   a;
        logic [DATA_W-1:0]   d;

        phase_mode = '{MIR_HORZ, MIR_ONE_LOW, MIR_ONE_HIGH, MIR_FOUR,
                       MIR_SPARE_A, MIR_SPARE_C, MIR_SPARE_B, MIR_VERT};
        phase_rom  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MIRROR;
        cfg_data          <= '0;
        acc_ch.valid      <= 1'b0;
        acc_ch.operation  <= OP_RD_BYTE;
        acc_ch.address    <= '0;
        acc_ch.write_data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(MIR_VERT, 1'b0);

        issue(OP_WR_BYTE, 14'h0000, 8'hff);
        issue(OP_WR_BYTE, 14'h0008, 8'ha5);
        issue(OP_RD_ROW,  14'h0000, 8'h00);
        issue(OP_RD_ROW,  14'h2000, 8'h00);
        issue(OP_WR_BYTE, 14'h1fff, 8'h00);
        issue(OP_RD_BYTE, 14'h1fff, 8'h00);
        issue(OP_RD_BYTE, 14'h0000, 8'h00);
        issue(OP_WR_BYTE, 14'h2000, 8'h11);
        issue(OP_WR_BYTE, 14'h2400, 8'h22);
        issue(OP_WR_BYTE, 14'h2800, 8'h33);
        issue(OP_WR_BYTE, 14'h2c00, 8'h44);
        issue(OP_RD_BYTE, 14'h2400, 8'h00);
        issue(OP_RD_BYTE, 14'h3000, 8'h00);
        issue(OP_WR_BYTE, 14'h3eff, 8'hee);
        issue(OP_RD_BYTE, 14'h2eff, 8'h00);
        issue(OP_WR_BYTE, 14'h3f00, 8'hff);
        issue(OP_RD_BYTE, 14'h3f10, 8'h00);
        issue(OP_WR_BYTE, 14'h3f30, 8'h2a);
        issue(OP_RD_BYTE, 14'h3f00, 8'h00);
        issue(OP_WR_BYTE, 14'h3fff, 8'h80);
        issue(OP_RD_BYTE, 14'h3f1f, 8'h00);
        issue(OP_NONE,    14'h3fff, 8'hff);
        issue(OP_RD_ROW,  14'h3fff, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            set_config(phase_mode[p], phase_rom[p]);
            if (p == FLOOD_PHASE) begin
                no_gaps = 1'b1;
                flood_req <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll_access(op, a, d);
                issue(op, a, d);
            end
            no_gaps = 1'b0;
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
